[sv/cna_pkg.sv]
// Shared types and codes for the complex-number ALU.
package cna_pkg;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_POW = 3'd4;
   localparam logic [2:0] CMD_NEG = 3'd5;

   typedef enum logic [3:0] {
      K_ZERO,
      K_ADD,
      K_SUB,
      K_NEG,
      K_DZ,
      K_ONE,
      K_PASS,
      K_MUL,
      K_POW,
      K_DIV
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] a_re;
      logic [31:0] a_im;
      logic [31:0] b_re;
      logic [31:0] b_im;
      logic [7:0]  expo;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_RND0,
      ST_RND1,
      ST_DSET,
      ST_DIT,
      ST_DFIN,
      ST_DONE
   } state_type;

endpackage

[sv/cna_front.sv]
// Front end: accepts request transactions, classifies them and queues them.
module cna_front #(
   parameter int WORD_BITS = 32,
   parameter int EXP_BITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_cmd,
   input  logic [31:0]       req_a_re,
   input  logic [31:0]       req_a_im,
   input  logic [31:0]       req_b_re,
   input  logic [31:0]       req_b_im,
   input  logic [7:0]        req_exponent,
   output logic              q_valid,
   output cna_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int W  = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int SH = 32 - W;
   localparam logic [7:0] EXP_MASK = (EXP_BITS >= 8) ? 8'hFF : 8'((1 << EXP_BITS) - 1);

   cna_pkg::item_type entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   cna_pkg::item_type item_in;
   logic              push;
   logic [31:0]       a_re_x, a_im_x, b_re_x, b_im_x;
   logic [7:0]        expo_m;

   function automatic logic [31:0] sext_w(input logic [31:0] v);
      logic [31:0] t;
      begin
         t = v << SH;
         return 32'($signed(t) >>> SH);
      end
   endfunction

   always_comb begin
      a_re_x = sext_w(req_a_re);
      a_im_x = sext_w(req_a_im);
      b_re_x = sext_w(req_b_re);
      b_im_x = sext_w(req_b_im);
      expo_m = req_exponent & EXP_MASK;
      item_in.a_re = a_re_x;
      item_in.a_im = a_im_x;
      item_in.b_re = b_re_x;
      item_in.b_im = b_im_x;
      item_in.expo = expo_m;
      unique case (req_cmd)
         cna_pkg::CMD_ADD: item_in.kind = cna_pkg::K_ADD;
         cna_pkg::CMD_SUB: item_in.kind = cna_pkg::K_SUB;
         cna_pkg::CMD_MUL: item_in.kind = cna_pkg::K_MUL;
         cna_pkg::CMD_DIV: begin
            if (b_re_x == 32'd0 && b_im_x == 32'd0) item_in.kind = cna_pkg::K_DZ;
            else item_in.kind = cna_pkg::K_DIV;
         end
         cna_pkg::CMD_POW: begin
            if (expo_m == 8'd0) item_in.kind = cna_pkg::K_ONE;
            else if (expo_m == 8'd1) item_in.kind = cna_pkg::K_PASS;
            else item_in.kind = cna_pkg::K_POW;
         end
         cna_pkg::CMD_NEG: item_in.kind = cna_pkg::K_NEG;
         default: item_in.kind = cna_pkg::K_ZERO;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[sv/cna_back.sv]
// Back end: sequencer with a shared multiplier and a bit-serial divider.
module cna_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cna_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_res_re,
   output logic [31:0]       rsp_res_im,
   output logic              rsp_overflow,
   output logic              rsp_div_zero
);

   localparam int W  = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int QB = W + 2;
   localparam int QW = $clog2(QB + 1);
   localparam int NW = 65 + FRAC_BITS;
   localparam int CW = 65 + ((FRAC_BITS + 1 > QB) ? FRAC_BITS + 1 : QB);
   localparam logic [65:0] NEG_LIM  = 66'd1 << (W - 1);
   localparam logic [65:0] RND_HALF = 66'd1 << (FRAC_BITS - 1);
   localparam logic [65:0] ONE_MAG  = 66'd1 << FRAC_BITS;

   cna_pkg::state_type state_ff, state_in;
   cna_pkg::kind_type  kind_ff, kind_in;
   logic signed [31:0] x_re_ff, x_re_in, x_im_ff, x_im_in;
   logic signed [31:0] y_re_ff, y_re_in, y_im_ff, y_im_in;
   logic [7:0]         pcnt_ff, pcnt_in;
   logic [2:0]         k_ff, k_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic               ov_ff, ov_in, dz_ff, dz_in;
   logic               comp_ff, comp_in;
   logic               sign_ff, sign_in;
   logic [65:0]        rem_ff, rem_in;
   logic [QB-1:0]      nlow_ff, nlow_in;
   logic [QB-1:0]      quo_ff, quo_in;
   logic [QW-1:0]      dcnt_ff, dcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_res_re_ff, rsp_res_re_in, rsp_res_im_ff, rsp_res_im_in;
   logic               rsp_overflow_ff, rsp_overflow_in, rsp_div_zero_ff, rsp_div_zero_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [31:0] ar, ai, br, bi;
   logic [32:0]        simp_re, simp_im, rnd_res, div_res;
   logic [2:0]         jdx, np;
   logic               sub_sel, out_free, is_div;
   logic signed [65:0] pext, pair_sum, dsel;
   logic [65:0]        dmag, rtmp, den_u;
   logic [NW-1:0]      nwide;
   logic               dovf, dge;
   logic [QB-1:0]      qr;

   function automatic logic [32:0] sat_sm(input logic neg, input logic [65:0] mag);
      logic [65:0] lim;
      logic [31:0] v;
      logic        o;
      begin
         lim = neg ? NEG_LIM : NEG_LIM - 66'd1;
         o   = mag > lim;
         v   = o ? lim[31:0] : mag[31:0];
         if (neg) v = 32'd0 - v;
         return {o, v};
      end
   endfunction

   function automatic logic [32:0] sat_sv(input logic signed [32:0] v);
      logic signed [65:0] vx;
      logic [65:0]        mag;
      begin
         vx  = 66'(v);
         mag = v[32] ? 66'd0 - vx : vx;
         return sat_sm(v[32], mag);
      end
   endfunction

   function automatic logic [32:0] rnd(input logic signed [65:0] acc);
      logic [65:0] mag;
      logic [65:0] m;
      begin
         mag = acc[65] ? 66'd0 - acc : acc;
         m   = (mag + RND_HALF) >> FRAC_BITS;
         return sat_sm(acc[65] && (m != 66'd0), m);
      end
   endfunction

   assign is_div   = (kind_ff == cna_pkg::K_DIV);
   assign np       = is_div ? 3'd6 : 3'd4;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ar = $signed(q_item.a_re);
      ai = $signed(q_item.a_im);
      br = $signed(q_item.b_re);
      bi = $signed(q_item.b_im);
      case (q_item.kind) inside
         cna_pkg::K_ADD: begin
            simp_re = sat_sv(33'(ar) + 33'(br));
            simp_im = sat_sv(33'(ai) + 33'(bi));
         end
         cna_pkg::K_SUB: begin
            simp_re = sat_sv(33'(ar) - 33'(br));
            simp_im = sat_sv(33'(ai) - 33'(bi));
         end
         cna_pkg::K_NEG: begin
            simp_re = sat_sm(ar > 0, ar < 0 ? 66'd0 - 66'(ar) : 66'(ar));
            simp_im = sat_sm(ai > 0, ai < 0 ? 66'd0 - 66'(ai) : 66'(ai));
         end
         cna_pkg::K_ONE: begin
            simp_re = sat_sm(1'b0, ONE_MAG);
            simp_im = 33'd0;
         end
         cna_pkg::K_PASS, cna_pkg::K_MUL, cna_pkg::K_POW, cna_pkg::K_DIV: begin
            simp_re = {1'b0, q_item.a_re};
            simp_im = {1'b0, q_item.a_im};
         end
         default: begin
            simp_re = 33'd0;
            simp_im = 33'd0;
         end
      endcase
   end

   always_comb begin
      case ({is_div, k_ff})
         {1'b0, 3'd0}: begin mul_a = x_re_ff; mul_b = y_re_ff; end
         {1'b0, 3'd1}: begin mul_a = x_im_ff; mul_b = y_im_ff; end
         {1'b0, 3'd2}: begin mul_a = x_re_ff; mul_b = y_im_ff; end
         {1'b0, 3'd3}: begin mul_a = x_im_ff; mul_b = y_re_ff; end
         {1'b1, 3'd0}: begin mul_a = y_re_ff; mul_b = y_re_ff; end
         {1'b1, 3'd1}: begin mul_a = y_im_ff; mul_b = y_im_ff; end
         {1'b1, 3'd2}: begin mul_a = x_re_ff; mul_b = y_re_ff; end
         {1'b1, 3'd3}: begin mul_a = x_im_ff; mul_b = y_im_ff; end
         {1'b1, 3'd4}: begin mul_a = x_im_ff; mul_b = y_re_ff; end
         {1'b1, 3'd5}: begin mul_a = x_re_ff; mul_b = y_im_ff; end
         default:      begin mul_a = x_re_ff; mul_b = y_re_ff; end
      endcase
      prod_in  = mul_a * mul_b;
      jdx      = k_ff - 3'd1;
      sub_sel  = (!is_div && jdx == 3'd1) || (is_div && jdx == 3'd5);
      pext     = 66'(prod_ff);
      pair_sum = sub_sel ? acc_ff - pext : acc_ff + pext;
      rnd_res  = rnd(state_ff == cna_pkg::ST_RND0 ? s0_ff : s1_ff);
      dsel     = comp_ff ? s2_ff : s1_ff;
      dmag     = dsel[65] ? 66'd0 - dsel : dsel;
      nwide    = NW'(dmag[63:0]) << (FRAC_BITS + 1);
      den_u    = $unsigned(s0_ff);
      dovf     = CW'(nwide) >= (CW'(den_u[63:0]) << QB);
      rtmp     = {rem_ff[64:0], nlow_ff[QB-1]};
      dge      = rtmp >= den_u;
      qr       = (quo_ff >> 1) + QB'(quo_ff[0]);
      if (state_ff == cna_pkg::ST_DSET) div_res = sat_sm(dsel[65], NEG_LIM + 66'd1);
      else div_res = sat_sm(sign_ff && (qr != '0), 66'(qr));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cna_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_item.kind == cna_pkg::K_MUL || q_item.kind == cna_pkg::K_POW ||
                   q_item.kind == cna_pkg::K_DIV) state_in = cna_pkg::ST_PROD;
               else state_in = cna_pkg::ST_DONE;
            end
         end
         cna_pkg::ST_PROD: begin
            if (k_ff == np) state_in = is_div ? cna_pkg::ST_DSET : cna_pkg::ST_RND0;
         end
         cna_pkg::ST_RND0: state_in = cna_pkg::ST_RND1;
         cna_pkg::ST_RND1: begin
            if (kind_ff == cna_pkg::K_POW && pcnt_ff != 8'd1) state_in = cna_pkg::ST_PROD;
            else state_in = cna_pkg::ST_DONE;
         end
         cna_pkg::ST_DSET: begin
            if (!dovf) state_in = cna_pkg::ST_DIT;
            else if (comp_ff) state_in = cna_pkg::ST_DONE;
         end
         cna_pkg::ST_DIT: begin
            if (dcnt_ff == QW'(1)) state_in = cna_pkg::ST_DFIN;
         end
         cna_pkg::ST_DFIN: state_in = comp_ff ? cna_pkg::ST_DONE : cna_pkg::ST_DSET;
         cna_pkg::ST_DONE: begin
            if (out_free) state_in = cna_pkg::ST_IDLE;
         end
         default: state_in = cna_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop           = 1'b0;
      kind_in         = kind_ff;
      x_re_in         = x_re_ff;
      x_im_in         = x_im_ff;
      y_re_in         = y_re_ff;
      y_im_in         = y_im_ff;
      pcnt_in         = pcnt_ff;
      k_in            = k_ff;
      acc_in          = acc_ff;
      s0_in           = s0_ff;
      s1_in           = s1_ff;
      s2_in           = s2_ff;
      ov_in           = ov_ff;
      dz_in           = dz_ff;
      comp_in         = comp_ff;
      sign_in         = sign_ff;
      rem_in          = rem_ff;
      nlow_in         = nlow_ff;
      quo_in          = quo_ff;
      dcnt_in         = dcnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_res_re_in   = rsp_res_re_ff;
      rsp_res_im_in   = rsp_res_im_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_div_zero_in = rsp_div_zero_ff;
      unique case (state_ff)
         cna_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               kind_in = q_item.kind;
               x_re_in = simp_re[31:0];
               x_im_in = simp_im[31:0];
               ov_in   = simp_re[32] | simp_im[32];
               dz_in   = (q_item.kind == cna_pkg::K_DZ);
               if (q_item.kind == cna_pkg::K_POW) begin
                  y_re_in = ar;
                  y_im_in = ai;
               end else begin
                  y_re_in = br;
                  y_im_in = bi;
               end
               pcnt_in = q_item.expo - 8'd1;
               k_in    = 3'd0;
               comp_in = 1'b0;
            end
         end
         cna_pkg::ST_PROD: begin
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               if (!jdx[0]) acc_in = pext;
               else begin
                  case (jdx[2:1])
                     2'd0:    s0_in = pair_sum;
                     2'd1:    s1_in = pair_sum;
                     default: s2_in = pair_sum;
                  endcase
               end
            end
         end
         cna_pkg::ST_RND0: begin
            x_re_in = rnd_res[31:0];
            ov_in   = ov_ff | rnd_res[32];
         end
         cna_pkg::ST_RND1: begin
            x_im_in = rnd_res[31:0];
            ov_in   = ov_ff | rnd_res[32];
            pcnt_in = pcnt_ff - 8'd1;
            k_in    = 3'd0;
         end
         cna_pkg::ST_DSET: begin
            sign_in = dsel[65];
            rem_in  = 66'(nwide >> QB);
            nlow_in = nwide[QB-1:0];
            quo_in  = '0;
            dcnt_in = QW'(QB);
            if (dovf) begin
               if (comp_ff) x_im_in = div_res[31:0];
               else x_re_in = div_res[31:0];
               ov_in   = ov_ff | div_res[32];
               comp_in = 1'b1;
            end
         end
         cna_pkg::ST_DIT: begin
            rem_in  = dge ? rtmp - den_u : rtmp;
            quo_in  = {quo_ff[QB-2:0], dge};
            nlow_in = nlow_ff << 1;
            dcnt_in = dcnt_ff - QW'(1);
         end
         cna_pkg::ST_DFIN: begin
            if (comp_ff) x_im_in = div_res[31:0];
            else x_re_in = div_res[31:0];
            ov_in   = ov_ff | div_res[32];
            comp_in = 1'b1;
         end
         cna_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_res_re_in   = x_re_ff;
               rsp_res_im_in   = x_im_ff;
               rsp_overflow_in = ov_ff;
               rsp_div_zero_in = dz_ff;
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cna_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      x_re_ff         <= x_re_in;
      x_im_ff         <= x_im_in;
      y_re_ff         <= y_re_in;
      y_im_ff         <= y_im_in;
      pcnt_ff         <= pcnt_in;
      k_ff            <= k_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      s0_ff           <= s0_in;
      s1_ff           <= s1_in;
      s2_ff           <= s2_in;
      ov_ff           <= ov_in;
      dz_ff           <= dz_in;
      comp_ff         <= comp_in;
      sign_ff         <= sign_in;
      rem_ff          <= rem_in;
      nlow_ff         <= nlow_in;
      quo_ff          <= quo_in;
      dcnt_ff         <= dcnt_in;
      rsp_res_re_ff   <= rsp_res_re_in;
      rsp_res_im_ff   <= rsp_res_im_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_div_zero_ff <= rsp_div_zero_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = rsp_res_re_ff;
   assign rsp_res_im   = rsp_res_im_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_div_zero = rsp_div_zero_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cna_pkg::ST_DIT) |-> (rem_ff < den_u))
      else $error("divider remainder not below denominator");

   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cna_pkg::ST_PROD && !is_div) |-> (k_ff <= 3'd4))
      else $error("multiply step count out of range");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_div_zero_ff) |->
         (rsp_res_re_ff == 32'd0 && rsp_res_im_ff == 32'd0 && !rsp_overflow_ff))
      else $error("divide by zero result not cleared");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cna_pkg::ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished transaction not presented");

   a_pow_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cna_pkg::ST_RND1 && kind_ff == cna_pkg::K_POW) |-> (pcnt_ff != 8'd0))
      else $error("power step counter underflow");

endmodule

[sv/complex_number_alu_top.sv]
// Top level of the complex-number ALU: front end, queue and back end.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  cmd, a_re, a_im, b_re, b_im, exponent
//   rsp_      out        rsp_valid / rsp_stall  res_re, res_im, overflow, div_zero
//
// Add, subtract, negate and the trivial powers skip the multiplier and go straight to the result.
// Multiply makes four passes through the one shared multiplier, then rounds both parts.
// Power n multiplies by the base n-1 times; divide uses the radix-2 divider,
// one quotient bit per cycle.
// Reset is synchronous and clears the queue, the sequencer and the result valid.
// A two-entry queue keeps accepting while the back end works or the result is stalled, until it is full.
module complex_number_alu_top #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter int EXP_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_a_re,
   input  logic [31:0] req_a_im,
   input  logic [31:0] req_b_re,
   input  logic [31:0] req_b_im,
   input  logic [7:0]  req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_res_re,
   output logic [31:0] rsp_res_im,
   output logic        rsp_overflow,
   output logic        rsp_div_zero
);

   logic              q_valid;
   logic              q_pop;
   cna_pkg::item_type q_item;

   cna_front #(
      .WORD_BITS(WORD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_a_re    (req_a_re),
      .req_a_im    (req_a_im),
      .req_b_re    (req_b_re),
      .req_b_im    (req_b_im),
      .req_exponent(req_exponent),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   cna_back #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res_re  (rsp_res_re),
      .rsp_res_im  (rsp_res_im),
      .rsp_overflow(rsp_overflow),
      .rsp_div_zero(rsp_div_zero)
   );

endmodule
